// File: sv/oqr_pkg.sv
// Shared constants, request codes and controller state type for the ordered queue.
package oqr_pkg;

    // Fixed field widths of the request and result transactions
    localparam int KIND_W   = 2;
    localparam int ID_W     = 16;
    localparam int HANDLE_W = 32;
    localparam int LENGTH_W = 10;
    localparam int TOTAL_W  = 5;

    // Default storage geometry
    localparam int DEPTH_DEF       = 16;
    localparam int ID_BITS_DEF     = 16;
    localparam int HANDLE_BITS_DEF = 32;
    localparam int LEN_BITS_DEF    = 10;
    localparam int ENTRY_W_DEF     = ID_BITS_DEF + HANDLE_BITS_DEF + LEN_BITS_DEF;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_POP    = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_HRD,
        ST_HLD,
        ST_DONE
    } state_t;

endpackage

// File: sv/oqr_req_if.sv
// Request channel interface: operation kind, id to remove, text handle and length.
interface oqr_req_if;
    logic                          valid;
    logic                          ready;
    logic [oqr_pkg::KIND_W-1:0]    kind;
    logic [oqr_pkg::ID_W-1:0]      req_id;
    logic [oqr_pkg::HANDLE_W-1:0]  text_handle;
    logic [oqr_pkg::LENGTH_W-1:0]  text_length;

    modport source (output valid, output kind, output req_id, output text_handle,
                    output text_length, input ready);
    modport sink   (input valid, input kind, input req_id, input text_handle,
                    input text_length, output ready);
endinterface

// File: sv/oqr_rsp_if.sv
// Result channel interface: status, assigned id, head entry and entry count.
interface oqr_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [oqr_pkg::ID_W-1:0]      assigned_id;
    logic                          head_valid;
    logic [oqr_pkg::ID_W-1:0]      head_id;
    logic [oqr_pkg::HANDLE_W-1:0]  head_handle;
    logic [oqr_pkg::LENGTH_W-1:0]  head_length;
    logic [oqr_pkg::TOTAL_W-1:0]   entry_total;

    modport source (output valid, output ok, output assigned_id, output head_valid,
                    output head_id, output head_handle, output head_length,
                    output entry_total, input ready);
    modport sink   (input valid, input ok, input assigned_id, input head_valid,
                    input head_id, input head_handle, input head_length,
                    input entry_total, output ready);
endinterface

// File: sv/ordered_queue_remove_by_id_core.sv
// Ordered bounded queue with append, remove-by-id and pop, entries kept in one RAM.
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+---------------------------------------------------------
//  req     | in  | valid/ready  | kind, req_id, text_handle, text_length
//  rsp     | out | valid/ready  | ok, assigned_id, head_valid, head_id, head_handle,
//          |     |              | head_length, entry_total
//
// One transaction is worked on at a time.
// Append, refused append, remove on an empty queue and unused kind go straight to the done state.
// Pop: if entries remain, the new head is fetched from the RAM (read state, then load state).
// Remove: the search walks the RAM one entry per cycle, stopping at the match or the last entry,
// and a gap left inside the queue is closed by a read/write copy loop.
// Reset is asynchronous and leaves the queue empty; the RAM is not cleared.
// A finished result waits in the output register while the next request is taken.

module ordered_queue_remove_by_id_core #(
    parameter int DEPTH       = oqr_pkg::DEPTH_DEF,
    parameter int ID_BITS     = oqr_pkg::ID_BITS_DEF,
    parameter int HANDLE_BITS = oqr_pkg::HANDLE_BITS_DEF,
    parameter int LEN_BITS    = oqr_pkg::LEN_BITS_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    oqr_req_if.sink   req,
    oqr_rsp_if.source rsp
);

    localparam int AW      = $clog2(DEPTH);       // physical slot address
    localparam int CW      = $clog2(DEPTH + 1);   // count / logical index
    localparam int ENTRY_W = ID_BITS + HANDLE_BITS + LEN_BITS;

    // Entries live in a circular buffer; logical index 0 is the head.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [CW-1:0] lidx);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(lidx);
        if (sum >= (CW+1)'(DEPTH))
        begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // Control state
    oqr_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    head_ptr_reg, head_ptr_next;
    logic             dv_reg, dv_next;        // read data valid for cpos_reg
    logic             out_valid_reg;

    // Working payload
    logic [CW-1:0]          idx_reg, idx_next;   // next logical index to read
    logic [CW-1:0]          cpos_reg, cpos_next; // logical index of the read data
    logic [ID_BITS-1:0]     tail_id_reg, tail_id_next;
    logic [ID_BITS-1:0]     prev_id_reg, prev_id_next;
    logic [ID_BITS-1:0]     want_reg, want_next;
    logic [ID_BITS-1:0]     hd_id_reg, hd_id_next;
    logic [HANDLE_BITS-1:0] hd_handle_reg, hd_handle_next;
    logic [LEN_BITS-1:0]    hd_len_reg, hd_len_next;
    logic                   ok_reg, ok_next;
    logic [ID_BITS-1:0]     given_reg, given_next;

    // Output register
    logic                          out_ok_reg;
    logic [oqr_pkg::ID_W-1:0]      out_given_reg;
    logic                          out_hv_reg;
    logic [oqr_pkg::ID_W-1:0]      out_hid_reg;
    logic [oqr_pkg::HANDLE_W-1:0]  out_hh_reg;
    logic [oqr_pkg::LENGTH_W-1:0]  out_hl_reg;
    logic [oqr_pkg::TOTAL_W-1:0]   out_total_reg;
    logic                          out_load;

    // RAM port signals
    logic               mem_wr_en;
    logic [AW-1:0]      mem_wr_addr;
    logic [ENTRY_W-1:0] mem_wr_data;
    logic               mem_rd_en;
    logic [AW-1:0]      mem_rd_addr;
    logic [ENTRY_W-1:0] mem_rd_data;

    logic [ID_BITS-1:0]     rd_id;
    logic [HANDLE_BITS-1:0] rd_handle;
    logic [LEN_BITS-1:0]    rd_len;
    logic [ID_BITS-1:0]     new_id;
    logic [HANDLE_BITS-1:0] new_handle;
    logic [LEN_BITS-1:0]    new_len;
    logic [AW-1:0]          head_inc;
    logic [CW-1:0]          last_idx;

    assign rd_id     = mem_rd_data[ENTRY_W-1 -: ID_BITS];
    assign rd_handle = mem_rd_data[LEN_BITS +: HANDLE_BITS];
    assign rd_len    = mem_rd_data[LEN_BITS-1:0];

    assign new_id     = (count_reg == '0) ? '0 : tail_id_reg + ID_BITS'(1);
    assign new_handle = HANDLE_BITS'(req.text_handle);
    assign new_len    = LEN_BITS'(req.text_length);
    assign head_inc   = (head_ptr_reg == AW'(DEPTH - 1)) ? '0 : head_ptr_reg + AW'(1);
    assign last_idx   = count_reg - CW'(1);

    oqr_entry_mem #(
        .DEPTH (DEPTH),
        .WIDTH (ENTRY_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        head_ptr_next  = head_ptr_reg;
        dv_next        = 1'b0;
        idx_next       = idx_reg;
        cpos_next      = cpos_reg;
        tail_id_next   = tail_id_reg;
        prev_id_next   = prev_id_reg;
        want_next      = want_reg;
        hd_id_next     = hd_id_reg;
        hd_handle_next = hd_handle_reg;
        hd_len_next    = hd_len_reg;
        ok_next        = ok_reg;
        given_next     = given_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = phys(head_ptr_reg, count_reg);
        mem_wr_data    = {new_id, new_handle, new_len};
        mem_rd_en      = 1'b0;
        mem_rd_addr    = phys(head_ptr_reg, idx_reg);
        out_load       = 1'b0;
        req.ready      = (state_reg == oqr_pkg::ST_IDLE);

        unique case (state_reg)
            oqr_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    ok_next    = 1'b0;
                    given_next = '0;
                    want_next  = ID_BITS'(req.req_id);
                    state_next = oqr_pkg::ST_DONE;
                    unique case (oqr_pkg::kind_t'(req.kind))
                        oqr_pkg::KIND_APPEND:
                        begin
                            if (count_reg < CW'(DEPTH))
                            begin
                                mem_wr_en    = 1'b1;
                                count_next   = count_reg + CW'(1);
                                tail_id_next = new_id;
                                given_next   = new_id;
                                ok_next      = 1'b1;
                                if (count_reg == '0)
                                begin
                                    hd_id_next     = new_id;
                                    hd_handle_next = new_handle;
                                    hd_len_next    = new_len;
                                end
                            end
                        end
                        oqr_pkg::KIND_REMOVE:
                        begin
                            if (count_reg != '0)
                            begin
                                idx_next   = '0;
                                state_next = oqr_pkg::ST_SEARCH;
                            end
                        end
                        oqr_pkg::KIND_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                ok_next       = 1'b1;
                                head_ptr_next = head_inc;
                                count_next    = last_idx;
                                if (count_reg > CW'(1))
                                begin
                                    state_next = oqr_pkg::ST_HRD;
                                end
                            end
                        end
                        default:
                        begin
                            // unused code: report current state only
                        end
                    endcase
                end
            end

            oqr_pkg::ST_SEARCH:
            begin
                // one read issued per cycle, compared when the registered read data returns
                mem_rd_en = (idx_reg < count_reg);
                cpos_next = idx_reg;
                dv_next   = mem_rd_en;
                if (mem_rd_en)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                if (dv_reg)
                begin
                    if (rd_id == want_reg)
                    begin
                        ok_next = 1'b1;
                        if (cpos_reg == '0)
                        begin
                            // matching head: same as a pop
                            head_ptr_next = head_inc;
                            count_next    = last_idx;
                            state_next    = (count_reg > CW'(1)) ? oqr_pkg::ST_HRD
                                                                 : oqr_pkg::ST_DONE;
                        end
                        else if (cpos_reg == last_idx)
                        begin
                            // matching tail: newest id falls back to its predecessor
                            count_next   = last_idx;
                            tail_id_next = prev_id_reg;
                            state_next   = oqr_pkg::ST_DONE;
                        end
                        else
                        begin
                            idx_next   = cpos_reg + CW'(1);
                            dv_next    = 1'b0;
                            state_next = oqr_pkg::ST_SHIFT;
                        end
                    end
                    else
                    begin
                        prev_id_next = rd_id;
                        if (cpos_reg == last_idx)
                        begin
                            state_next = oqr_pkg::ST_DONE;
                        end
                    end
                end
            end

            oqr_pkg::ST_SHIFT:
            begin
                // copy entry i to i-1; reads run two slots ahead of writes
                mem_rd_en = (idx_reg < count_reg);
                cpos_next = idx_reg;
                dv_next   = mem_rd_en;
                if (mem_rd_en)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                if (dv_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = phys(head_ptr_reg, cpos_reg - CW'(1));
                    mem_wr_data = mem_rd_data;
                    if (cpos_reg == last_idx)
                    begin
                        count_next = last_idx;
                        state_next = oqr_pkg::ST_DONE;
                    end
                end
            end

            oqr_pkg::ST_HRD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = head_ptr_reg;
                state_next  = oqr_pkg::ST_HLD;
            end

            oqr_pkg::ST_HLD:
            begin
                hd_id_next     = rd_id;
                hd_handle_next = rd_handle;
                hd_len_next    = rd_len;
                state_next     = oqr_pkg::ST_DONE;
            end

            oqr_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = oqr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = oqr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= oqr_pkg::ST_IDLE;
            count_reg     <= '0;
            head_ptr_reg  <= '0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            head_ptr_reg <= head_ptr_next;
            dv_reg       <= dv_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        cpos_reg      <= cpos_next;
        tail_id_reg   <= tail_id_next;
        prev_id_reg   <= prev_id_next;
        want_reg      <= want_next;
        hd_id_reg     <= hd_id_next;
        hd_handle_reg <= hd_handle_next;
        hd_len_reg    <= hd_len_next;
        ok_reg        <= ok_next;
        given_reg     <= given_next;
        if (out_load)
        begin
            out_ok_reg    <= ok_reg;
            out_given_reg <= oqr_pkg::ID_W'(given_reg);
            out_hv_reg    <= (count_reg != '0);
            out_hid_reg   <= (count_reg != '0) ? oqr_pkg::ID_W'(hd_id_reg) : '0;
            out_hh_reg    <= (count_reg != '0) ? oqr_pkg::HANDLE_W'(hd_handle_reg) : '0;
            out_hl_reg    <= (count_reg != '0) ? oqr_pkg::LENGTH_W'(hd_len_reg) : '0;
            out_total_reg <= oqr_pkg::TOTAL_W'(count_reg);
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.ok          = out_ok_reg;
    assign rsp.assigned_id = out_given_reg;
    assign rsp.head_valid  = out_hv_reg;
    assign rsp.head_id     = out_hid_reg;
    assign rsp.head_handle = out_hh_reg;
    assign rsp.head_length = out_hl_reg;
    assign rsp.entry_total = out_total_reg;

endmodule

// File: sv/oqr_entry_mem.sv
// Entry storage: one write port and one read port with registered read data.
module oqr_entry_mem #(
    parameter int DEPTH = oqr_pkg::DEPTH_DEF,
    parameter int WIDTH = oqr_pkg::ENTRY_W_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] entry_mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
